@@ hdl/gsp_pkg.sv @@
// Shared types, codes and helpers for the gear selector.
package gsp_pkg;

  localparam int LEVEL_W  = 12;
  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 16;
  localparam int CFG_W    = 16;
  localparam int GEAR_W   = 2;
  localparam int LAMP_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int NUM_BUTTONS = 3;
  localparam int SUM_W    = LEVEL_W + 2;

  localparam logic [1:0] MODE_SAMPLES = 2'd0;
  localparam logic [1:0] MODE_BUTTON  = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 2'd0;
  localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_REVERSE = 2'd2;

  localparam logic [LAMP_W-1:0] LAMP_NEUTRAL = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_REVERSE = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_DRIVE   = 3'b100;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 12'd2200;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 16'd20;

  typedef struct packed {
    logic [LEVEL_W-1:0]  threshold;
    logic [WINDOW_W-1:0] window;
  } cfg_t;

  typedef struct packed {
    logic [GEAR_W-1:0]  gear_now;
    logic [LAMP_W-1:0]  led_lamps;
    logic [LEVEL_W-1:0] level_now;
    logic               shift_taken;
    logic               frame_valid;
    logic [BYTE_W-1:0]  frame_high;
    logic [BYTE_W-1:0]  frame_low;
  } res_t;

  function automatic logic [LAMP_W-1:0] lamps_for(input logic [GEAR_W-1:0] g);
    logic [LAMP_W-1:0] l;
    case (g)
      GEAR_DRIVE:   l = LAMP_DRIVE;
      GEAR_REVERSE: l = LAMP_REVERSE;
      default:      l = LAMP_NEUTRAL;
    endcase
    return l;
  endfunction

endpackage

@@ hdl/gsp_lane.sv @@
// One button lane: last accepted press time and its debounce check.
module gsp_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gsp_pkg::TIME_W-1:0]   now_ms,
  input  logic [gsp_pkg::WINDOW_W-1:0] window,
  input  logic                         commit,
  output logic                         ok
);
  import gsp_pkg::*;

  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_ms - last_time;
  assign ok = elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (commit) begin
      last_time <= now_ms;
    end
  end

endmodule

@@ hdl/gsp_core.sv @@
// Gear and pedal state, button lanes and the merge of their results.
module gsp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  gsp_pkg::cfg_t               cfg,
  input  logic [1:0]                  mode,
  input  logic [gsp_pkg::LEVEL_W-1:0] sample_a,
  input  logic [gsp_pkg::LEVEL_W-1:0] sample_b,
  input  logic [gsp_pkg::LEVEL_W-1:0] sample_c,
  input  logic [gsp_pkg::LEVEL_W-1:0] sample_d,
  input  logic [1:0]                  button,
  input  logic [gsp_pkg::TIME_W-1:0]  now_ms,
  output gsp_pkg::res_t               res
);
  import gsp_pkg::*;

  logic [GEAR_W-1:0]      gear, gear_next;
  logic [LEVEL_W-1:0]     level, level_next;
  logic [SUM_W-1:0]       sum;
  logic                   allow;
  logic [NUM_BUTTONS-1:0] sel, ok, commit;
  logic                   taken;

  assign sum = {2'b00, sample_a} + {2'b00, sample_b} + {2'b00, sample_c} + {2'b00, sample_d};

  assign allow = (mode == MODE_BUTTON) && (level < cfg.threshold) &&
                 ((button == GEAR_NEUTRAL) || (gear == GEAR_NEUTRAL));

  genvar i;
  generate
    for (i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      assign sel[i]    = allow && (button == GEAR_W'(i));
      assign commit[i] = take && sel[i] && ok[i];
      gsp_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .now_ms (now_ms),
        .window (cfg.window),
        .commit (commit[i]),
        .ok     (ok[i])
      );
    end
  endgenerate

  assign taken = |(sel & ok);

  always_comb begin
    gear_next = gear;
    level_next = level;
    res = '0;
    case (mode)
      MODE_SAMPLES: level_next = sum[SUM_W-1:2];
      MODE_BUTTON: begin
        if (taken) gear_next = button;
        res.shift_taken = taken;
      end
      MODE_TICK: begin
        res.frame_valid = 1'b1;
        res.frame_high  = {gear, 2'b00, level[LEVEL_W-1:8]};
        res.frame_low   = level[7:0];
      end
      default: ;
    endcase
    res.gear_now  = gear_next;
    res.led_lamps = lamps_for(gear_next);
    res.level_now = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gear  <= GEAR_NEUTRAL;
      level <= '0;
    end else if (take) begin
      gear  <= gear_next;
      level <= level_next;
    end
  end

endmodule

@@ hdl/gsp_skid.sv @@
// Output register with one skid entry for result items.
module gsp_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  gsp_pkg::res_t res_in,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output gsp_pkg::res_t res_out
);
  import gsp_pkg::*;

  res_t skid_data;
  logic skid_valid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        res_out    <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
        if (take) res_out <= res_in;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
      skid_data  <= res_in;
    end
  end

endmodule

@@ hdl/gear_selector_with_pedal_interlock.sv @@
// Top level: gear selector with pedal interlock, config registers and output staging.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    mode, sample_a..d, button, now_ms
//   output    out_valid / out_stall  gear_now, led_lamps, level_now, shift_taken, frame_*
//   config    cfg_write              cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each item yields one registered result.
// The three button lanes and the merge resolve a press in the accept cycle.
// Output register plus one skid entry: input stalls only while the skid is full.
// Synchronous reset: neutral gear, level 0, press times 0, threshold 2200, window 20.
module gear_selector_with_pedal_interlock (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [gsp_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [gsp_pkg::LEVEL_W-1:0]  sample_a,
  input  logic [gsp_pkg::LEVEL_W-1:0]  sample_b,
  input  logic [gsp_pkg::LEVEL_W-1:0]  sample_c,
  input  logic [gsp_pkg::LEVEL_W-1:0]  sample_d,
  input  logic [1:0]                   button,
  input  logic [gsp_pkg::TIME_W-1:0]   now_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gsp_pkg::GEAR_W-1:0]   gear_now,
  output logic [gsp_pkg::LAMP_W-1:0]   led_lamps,
  output logic [gsp_pkg::LEVEL_W-1:0]  level_now,
  output logic                         shift_taken,
  output logic                         frame_valid,
  output logic [gsp_pkg::BYTE_W-1:0]   frame_high,
  output logic [gsp_pkg::BYTE_W-1:0]   frame_low
);
  import gsp_pkg::*;

  cfg_t cfg;
  res_t res, res_q;
  logic take, full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.window    <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold <= cfg_data[LEVEL_W-1:0];
        REG_WINDOW:    cfg.window    <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign take = in_valid && !full;

  gsp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cfg      (cfg),
    .mode     (mode),
    .sample_a (sample_a),
    .sample_b (sample_b),
    .sample_c (sample_c),
    .sample_d (sample_d),
    .button   (button),
    .now_ms   (now_ms),
    .res      (res)
  );

  gsp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_in    (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign gear_now    = res_q.gear_now;
  assign led_lamps   = res_q.led_lamps;
  assign level_now   = res_q.level_now;
  assign shift_taken = res_q.shift_taken;
  assign frame_valid = res_q.frame_valid;
  assign frame_high  = res_q.frame_high;
  assign frame_low   = res_q.frame_low;

endmodule
